[rtl/lis_pkg.sv]
package lis_pkg;

    localparam int LIS_MAX_LEN    = 1024;
    localparam int LIS_VALUE_BITS = 32;
    localparam int COUNT_W        = 11;

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_FIN    = 4'b0100,
        ST_OUT    = 4'b1000
    } t_state;

    // Control from the sequencer to the search unit.
    typedef struct packed {
        logic start;
        logic step;
    } t_search_ctl;

endpackage

[rtl/lis_if.sv]
interface lis_in_if #(
    parameter int VALUE_BITS = lis_pkg::LIS_VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         first;

    modport source(output valid, output value, output first, input ready);
    modport sink(input valid, input value, input first, output ready);
endinterface

interface lis_out_if;
    logic                 valid;
    logic                 ready;
    lis_pkg::t_count      rank;
    lis_pkg::t_count      best_length;
    logic                 overflow;

    modport source(output valid, output rank, output best_length, output overflow,
                   input ready);
    modport sink(input valid, input rank, input best_length, input overflow,
                 output ready);
endinterface

[rtl/longest_increasing_subsequence.sv]
// Streaming longest strictly increasing subsequence.
// The input channel carries one signed value per transaction together with a
// first flag that starts a new sequence. The output channel returns one
// transaction per input: the length of the longest strictly increasing
// subsequence ending at that value (rank), the longest length so far and an
// overflow flag that sticks once an append was lost to a full tail store.
// Each item runs a lower-bound binary search over the stored tails, one
// probe per cycle through a single comparator fed by the registered read
// port of the tail memory. An item is accepted, then probed until the
// search closes, then written back, after which the result enters the
// output register.
// The input is ready only in the idle state. A finished result waits in the
// output register, so a new item may be accepted while the receiver stalls;
// its result then waits in a hold register until the output register frees.
// Reset clears the length, the overflow flag and the handshake state; the
// tail memory needs no clearing: only entries below the length are compared.
module longest_increasing_subsequence #(
    parameter int MAX_LEN    = lis_pkg::LIS_MAX_LEN,
    parameter int VALUE_BITS = lis_pkg::LIS_VALUE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lis_in_if.sink    i_in,
    lis_out_if.source o_out
);
    import lis_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam logic [LEN_W-1:0] MaxLenC = LEN_W'(MAX_LEN);

    t_state                       r_state, n_state;
    logic [LEN_W-1:0]             r_len, n_len;
    logic                         r_lost, n_lost;
    logic signed [VALUE_BITS-1:0] r_key;

    // Result held when the output register is still occupied.
    t_count                       r_res_rank, r_res_best;
    logic                         r_res_ovf;

    logic                         r_out_valid;
    t_count                       r_out_rank, r_out_best;
    logic                         r_out_ovf;

    t_search_ctl                  w_ctl;
    logic [LEN_W-1:0]             w_start_len;
    logic [ADDR_W-1:0]            w_raddr, w_waddr;
    logic signed [VALUE_BITS-1:0] w_rdata;
    logic                         w_done;
    logic [LEN_W-1:0]             w_pos;
    logic                         w_accept, w_out_free, w_at_end, w_full, w_we;
    logic [LEN_W-1:0]             w_rank;
    logic [LEN_W+COUNT_W-1:0]     w_rank_ext, w_len_ext;
    t_count                       w_fin_rank, w_fin_best;

    assign i_in.ready  = r_state == ST_IDLE;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // A first flag empties the store before the search starts.
    assign w_start_len = i_in.first ? '0 : r_len;
    assign w_ctl.start = w_accept;
    assign w_ctl.step  = r_state == ST_SEARCH;

    lis_search #(
        .MAX_LEN   (MAX_LEN),
        .VALUE_BITS(VALUE_BITS),
        .ADDR_W    (ADDR_W),
        .LEN_W     (LEN_W)
    ) u_search (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_len  (w_start_len),
        .i_key  (r_key),
        .i_rdata(w_rdata),
        .o_raddr(w_raddr),
        .o_done (w_done),
        .o_pos  (w_pos)
    );

    // The search ending past the last tail means the value beats every tail
    // and is appended, unless the store is already full.
    assign w_at_end = w_pos == r_len;
    assign w_full   = r_len == MaxLenC;
    assign w_we     = (r_state == ST_FIN) && !(w_at_end && w_full);
    assign w_waddr  = w_at_end ? r_len[ADDR_W-1:0] : w_pos[ADDR_W-1:0];

    lis_tail_mem #(
        .MAX_LEN   (MAX_LEN),
        .VALUE_BITS(VALUE_BITS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_key),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_len  = r_len;
        n_lost = r_lost;
        w_rank = w_pos + LEN_W'(1);
        if (w_accept && i_in.first) begin
            n_len  = '0;
            n_lost = 1'b0;
        end else if (r_state == ST_FIN && w_at_end) begin
            if (w_full) begin
                n_lost = 1'b1;
                w_rank = MaxLenC;
            end else begin
                n_len  = r_len + LEN_W'(1);
                w_rank = r_len + LEN_W'(1);
            end
        end
    end

    // Counts are reported modulo the output width.
    assign w_rank_ext = {{COUNT_W{1'b0}}, w_rank};
    assign w_len_ext  = {{COUNT_W{1'b0}}, n_len};
    assign w_fin_rank = w_rank_ext[COUNT_W-1:0];
    assign w_fin_best = w_len_ext[COUNT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_done ? ST_FIN : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = w_out_free ? ST_IDLE : ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_lost      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_lost  <= n_lost;
            if ((r_state == ST_FIN || r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_in.value;
        end
        if (r_state == ST_FIN) begin
            r_res_rank <= w_fin_rank;
            r_res_best <= w_fin_best;
            r_res_ovf  <= n_lost;
        end
        if (w_out_free) begin
            if (r_state == ST_FIN) begin
                r_out_rank <= w_fin_rank;
                r_out_best <= w_fin_best;
                r_out_ovf  <= n_lost;
            end else if (r_state == ST_OUT) begin
                r_out_rank <= r_res_rank;
                r_out_best <= r_res_best;
                r_out_ovf  <= r_res_ovf;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.rank        = r_out_rank;
    assign o_out.best_length = r_out_best;
    assign o_out.overflow    = r_out_ovf;

endmodule

[rtl/lis_tail_mem.sv]
module lis_tail_mem #(
    parameter int MAX_LEN    = lis_pkg::LIS_MAX_LEN,
    parameter int VALUE_BITS = lis_pkg::LIS_VALUE_BITS,
    parameter int ADDR_W     = $clog2(MAX_LEN)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic signed [VALUE_BITS-1:0] i_wdata,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic signed [VALUE_BITS-1:0] o_rdata
);
    import lis_pkg::*;

    logic signed [VALUE_BITS-1:0] r_mem [MAX_LEN];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/lis_search.sv]
module lis_search #(
    parameter int MAX_LEN    = lis_pkg::LIS_MAX_LEN,
    parameter int VALUE_BITS = lis_pkg::LIS_VALUE_BITS,
    parameter int ADDR_W     = $clog2(MAX_LEN),
    parameter int LEN_W      = $clog2(MAX_LEN + 1)
) (
    input  logic                         i_clk,
    input  lis_pkg::t_search_ctl         i_ctl,
    input  logic [LEN_W-1:0]             i_len,
    input  logic signed [VALUE_BITS-1:0] i_key,
    input  logic signed [VALUE_BITS-1:0] i_rdata,
    output logic [ADDR_W-1:0]            o_raddr,
    output logic                         o_done,
    output logic [LEN_W-1:0]             o_pos
);
    import lis_pkg::*;

    logic [LEN_W-1:0] r_lo, r_hi, r_mid;
    logic [LEN_W-1:0] n_lo, n_hi, n_mid;
    logic [LEN_W:0]   w_sum;
    logic             w_lt;

    // The tail read back belongs to the probe at r_mid.
    assign w_lt = i_rdata < i_key;

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_ctl.start) begin
            n_lo = '0;
            n_hi = i_len;
        end else if (i_ctl.step) begin
            if (w_lt) begin
                n_lo = r_mid + LEN_W'(1);
            end else begin
                n_hi = r_mid;
            end
        end
    end

    assign w_sum   = {1'b0, n_lo} + {1'b0, n_hi};
    assign n_mid   = w_sum[LEN_W:1];
    assign o_raddr = n_mid[ADDR_W-1:0];
    assign o_done  = n_lo == n_hi;
    assign o_pos   = r_lo;

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
    end

endmodule
